### design/csf_pkg.sv
// Shared types, codes and sizes for the counting semaphore with waiter FIFO.
package csf_pkg;

    localparam int QUEUE_DEPTH     = 16;
    localparam int THREAD_ID_WIDTH = 8;
    localparam int COUNT_WIDTH     = 16;
    localparam int FREE_WIDTH      = 32;
    localparam int IDX_WIDTH       = $clog2(QUEUE_DEPTH);
    localparam int TOTAL_WIDTH     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_WAIT        = 2'd0;
    localparam logic [1:0] KIND_SIGNAL      = 2'd1;
    localparam logic [1:0] KIND_RELEASE_ALL = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO      = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [THREAD_ID_WIDTH-1:0] thread_id;
        logic [COUNT_WIDTH-1:0]     unit_count;
    } req_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic                       caller_blocked;
        logic                       released_valid;
        logic [THREAD_ID_WIDTH-1:0] released_thread;
        logic                       last;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_READ  = 5'b00100,
        S_PAY   = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    function automatic logic [IDX_WIDTH-1:0] next_slot(input logic [IDX_WIDTH-1:0] idx);
        logic [IDX_WIDTH-1:0] res;
        if (idx == IDX_WIDTH'(QUEUE_DEPTH - 1))
            res = '0;
        else
            res = idx + IDX_WIDTH'(1);
        return res;
    endfunction

endpackage

### design/counting_semaphore_fifo_n.sv
// Counting semaphore taking and giving n units, with a FIFO of blocked waiters.
//
//   channel | signals                        | payload
//   --------+--------------------------------+-------------------------------
//   req     | req_valid / req_ready          | req_data  (kind, thread_id, unit_count)
//   rsp     | rsp_valid / rsp_ready          | rsp_data  (status, blocked, release, last)
//   cfg     | cfg_wr_en                      | cfg_wr_data (initial_count)
//
// A wait, a rejected or ignored request is accepted, then decoded in S_EXEC.
// A signal or release-all walks the waiter FIFO through one head read port:
// each waiter touched is read (S_READ) then paid (S_PAY); a signal closes out in S_FLUSH.
// Reset clears the counters and the free count; FIFO entries hold junk until written.
// req_ready is high only between items; a full result register stalls the sequencer.
module counting_semaphore_fifo_n (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  csf_pkg::req_t                     req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output csf_pkg::rsp_t                     rsp_data,
    input  logic                              cfg_wr_en,
    input  logic [csf_pkg::COUNT_WIDTH-1:0]   cfg_wr_data
);

    csf_pkg::state_t                          state_reg, state_next;
    logic [csf_pkg::FREE_WIDTH-1:0]           free_reg, free_next;
    logic [csf_pkg::IDX_WIDTH-1:0]            head_reg, head_next;
    logic [csf_pkg::IDX_WIDTH-1:0]            tail_reg, tail_next;
    logic [csf_pkg::TOTAL_WIDTH-1:0]          total_reg, total_next;
    logic [1:0]                               kind_reg, kind_next;
    logic [csf_pkg::THREAD_ID_WIDTH-1:0]      tid_reg, tid_next;
    logic [csf_pkg::COUNT_WIDTH-1:0]          avail_reg, avail_next;
    logic                                     pend_reg, pend_next;
    logic [csf_pkg::THREAD_ID_WIDTH-1:0]      pend_tid_reg, pend_tid_next;
    logic                                     out_valid_reg, out_valid_next;
    csf_pkg::rsp_t                            out_data_reg, out_data_next;
    logic [csf_pkg::THREAD_ID_WIDTH-1:0]      rd_tid_reg;
    logic [csf_pkg::COUNT_WIDTH-1:0]          rd_need_reg;

    logic [csf_pkg::THREAD_ID_WIDTH-1:0]      waiter_thread_mem [csf_pkg::QUEUE_DEPTH];
    logic [csf_pkg::COUNT_WIDTH-1:0]          waiter_need_mem   [csf_pkg::QUEUE_DEPTH];

    logic                                     mem_we;
    logic [csf_pkg::IDX_WIDTH-1:0]            mem_addr;
    logic [csf_pkg::THREAD_ID_WIDTH-1:0]      mem_wr_tid;
    logic [csf_pkg::COUNT_WIDTH-1:0]          mem_wr_need;

    logic                                     out_free;
    logic [csf_pkg::FREE_WIDTH:0]             sum;
    logic [csf_pkg::FREE_WIDTH-1:0]           sat_free;
    logic [csf_pkg::COUNT_WIDTH-1:0]          left_after;
    logic                                     short_avail;

    assign req_ready = (state_reg == csf_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;
    assign out_free  = !out_valid_reg || rsp_ready;

    // Saturating add of leftover units to the free count
    assign sum      = {1'b0, free_reg} + (csf_pkg::FREE_WIDTH + 1)'(avail_reg);
    assign sat_free = sum[csf_pkg::FREE_WIDTH] ? '1 : sum[csf_pkg::FREE_WIDTH-1:0];

    assign short_avail = (avail_reg < rd_need_reg);
    assign left_after  = avail_reg - rd_need_reg;

    always_comb
    begin
        state_next     = state_reg;
        free_next      = free_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        total_next     = total_reg;
        kind_next      = kind_reg;
        tid_next       = tid_reg;
        avail_next     = avail_reg;
        pend_next      = pend_reg;
        pend_tid_next  = pend_tid_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_addr       = tail_reg;
        mem_wr_tid     = tid_reg;
        mem_wr_need    = avail_reg;

        unique case (state_reg)
            csf_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = req_data.kind;
                    tid_next   = req_data.thread_id;
                    avail_next = req_data.unit_count;
                    pend_next  = 1'b0;
                    state_next = csf_pkg::S_EXEC;
                end
            end

            csf_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    out_data_next      = '0;
                    out_data_next.last = 1'b1;
                    state_next         = csf_pkg::S_IDLE;
                    unique case (kind_reg)
                        csf_pkg::KIND_RELEASE_ALL:
                        begin
                            if (total_reg != '0)
                                state_next = csf_pkg::S_READ;
                            else
                                out_valid_next = 1'b1;
                        end
                        csf_pkg::KIND_WAIT:
                        begin
                            out_valid_next = 1'b1;
                            if (avail_reg == '0)
                                out_data_next.status = csf_pkg::STATUS_ZERO;
                            else if (total_reg != '0)
                            begin
                                if (total_reg == csf_pkg::TOTAL_WIDTH'(csf_pkg::QUEUE_DEPTH))
                                    out_data_next.status = csf_pkg::STATUS_FULL;
                                else
                                begin
                                    mem_we                       = 1'b1;
                                    tail_next                    = csf_pkg::next_slot(tail_reg);
                                    total_next                   = total_reg + 1'b1;
                                    out_data_next.caller_blocked = 1'b1;
                                end
                            end
                            else if (free_reg >= csf_pkg::FREE_WIDTH'(avail_reg))
                                free_next = free_reg - csf_pkg::FREE_WIDTH'(avail_reg);
                            else
                            begin
                                // shortfall fits the count width since free < request
                                mem_we      = 1'b1;
                                mem_wr_need = avail_reg - free_reg[csf_pkg::COUNT_WIDTH-1:0];
                                free_next   = '0;
                                tail_next   = csf_pkg::next_slot(tail_reg);
                                total_next  = total_reg + 1'b1;
                                out_data_next.caller_blocked = 1'b1;
                            end
                        end
                        csf_pkg::KIND_SIGNAL:
                        begin
                            if (avail_reg == '0)
                            begin
                                out_valid_next       = 1'b1;
                                out_data_next.status = csf_pkg::STATUS_ZERO;
                            end
                            else if (total_reg != '0)
                                state_next = csf_pkg::S_READ;
                            else
                                state_next = csf_pkg::S_FLUSH;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            csf_pkg::S_READ:
            begin
                state_next = csf_pkg::S_PAY;
            end

            csf_pkg::S_PAY:
            begin
                if (out_free)
                begin
                    out_data_next = '0;
                    if (kind_reg == csf_pkg::KIND_RELEASE_ALL)
                    begin
                        head_next                     = csf_pkg::next_slot(head_reg);
                        total_next                    = total_reg - 1'b1;
                        out_valid_next                = 1'b1;
                        out_data_next.released_valid  = 1'b1;
                        out_data_next.released_thread = rd_tid_reg;
                        out_data_next.last            = (total_reg == csf_pkg::TOTAL_WIDTH'(1));
                        state_next = (total_reg == csf_pkg::TOTAL_WIDTH'(1)) ?
                                     csf_pkg::S_IDLE : csf_pkg::S_READ;
                    end
                    else if (short_avail)
                    begin
                        // partial fill of the head waiter
                        mem_we      = 1'b1;
                        mem_addr    = head_reg;
                        mem_wr_tid  = rd_tid_reg;
                        mem_wr_need = rd_need_reg - avail_reg;
                        avail_next  = '0;
                        state_next  = csf_pkg::S_FLUSH;
                    end
                    else
                    begin
                        // the held release is not final; send it and hold this one
                        head_next     = csf_pkg::next_slot(head_reg);
                        total_next    = total_reg - 1'b1;
                        avail_next    = left_after;
                        pend_next     = 1'b1;
                        pend_tid_next = rd_tid_reg;
                        if (pend_reg)
                        begin
                            out_valid_next                = 1'b1;
                            out_data_next.released_valid  = 1'b1;
                            out_data_next.released_thread = pend_tid_reg;
                        end
                        if (left_after == '0 || total_reg == csf_pkg::TOTAL_WIDTH'(1))
                            state_next = csf_pkg::S_FLUSH;
                        else
                            state_next = csf_pkg::S_READ;
                    end
                end
            end

            csf_pkg::S_FLUSH:
            begin
                if (out_free)
                begin
                    free_next                     = sat_free;
                    out_valid_next                = 1'b1;
                    out_data_next                 = '0;
                    out_data_next.released_valid  = pend_reg;
                    out_data_next.released_thread = pend_reg ? pend_tid_reg : '0;
                    out_data_next.last            = 1'b1;
                    pend_next                     = 1'b0;
                    state_next                    = csf_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = csf_pkg::S_IDLE;
            end
        endcase

        if (cfg_wr_en)
            free_next = csf_pkg::FREE_WIDTH'(cfg_wr_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csf_pkg::S_IDLE;
            free_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            total_reg     <= total_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        tid_reg      <= tid_next;
        avail_reg    <= avail_next;
        pend_tid_reg <= pend_tid_next;
        out_data_reg <= out_data_next;
    end

    // Waiter FIFO storage: one write port, registered head read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            waiter_thread_mem[mem_addr] <= mem_wr_tid;
            waiter_need_mem[mem_addr]   <= mem_wr_need;
        end
        if (state_reg == csf_pkg::S_READ)
        begin
            rd_tid_reg  <= waiter_thread_mem[head_reg];
            rd_need_reg <= waiter_need_mem[head_reg];
        end
    end

`ifndef ASSERT_OFF
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= csf_pkg::TOTAL_WIDTH'(csf_pkg::QUEUE_DEPTH))
        else $error("waiter count exceeds FIFO depth");

    a_ring_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg == '0 || total_reg == csf_pkg::TOTAL_WIDTH'(csf_pkg::QUEUE_DEPTH))
        |-> head_reg == tail_reg)
        else $error("head and tail disagree with waiter count");

    a_pay_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csf_pkg::S_READ || state_reg == csf_pkg::S_PAY) |-> total_reg != '0)
        else $error("walking an empty waiter FIFO");

    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (kind_reg == csf_pkg::KIND_SIGNAL &&
                      (state_reg == csf_pkg::S_READ || state_reg == csf_pkg::S_PAY ||
                       state_reg == csf_pkg::S_FLUSH)))
        else $error("held release outside a signal walk");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> state_reg == csf_pkg::S_EXEC)
        else $error("accepted request not decoded");
`endif

endmodule

### bench/counting_semaphore_fifo_n_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multi-unit counting semaphore with its waiter FIFO.
module counting_semaphore_fifo_n_tb;

    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int BIG_SIGNALS   = 6;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    csf_pkg::req_t                   req_data = '0;
    logic                            rsp_valid;
    logic                            rsp_ready = 1'b0;
    csf_pkg::rsp_t                   rsp_data;
    logic                            cfg_wr_en = 1'b0;
    logic [csf_pkg::COUNT_WIDTH-1:0] cfg_wr_data = '0;

    // predicted semaphore state
    logic [csf_pkg::FREE_WIDTH-1:0]      free_units_m = '0;
    logic [csf_pkg::THREAD_ID_WIDTH-1:0] waiter_tid[csf_pkg::QUEUE_DEPTH];
    logic [csf_pkg::COUNT_WIDTH-1:0]     waiter_need[csf_pkg::QUEUE_DEPTH];
    logic [csf_pkg::IDX_WIDTH-1:0]       wq_head = '0;
    logic [csf_pkg::IDX_WIDTH-1:0]       wq_tail = '0;
    int                                  wq_count = 0;

    csf_pkg::rsp_t expected_rsp[$];
    int   error_count = 0;
    int   requests_sent = 0;
    int   responses_seen = 0;
    int   cycle_count = 0;
    int   rsp_stall_left = 0;
    bit   req_idle_on = 1'b1;
    bit   rsp_idle_on = 1'b1;

    counting_semaphore_fifo_n dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_data    (rsp_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("counting_semaphore_fifo_n_tb: errors");
            $finish;
        end
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic csf_pkg::req_t make_req(input logic [1:0] kind, input int tid,
                                               input int n);
        csf_pkg::req_t r;
        r.kind       = kind;
        r.thread_id  = csf_pkg::THREAD_ID_WIDTH'(tid);
        r.unit_count = csf_pkg::COUNT_WIDTH'(n);
        return r;
    endfunction

    task automatic waiter_push(input logic [csf_pkg::THREAD_ID_WIDTH-1:0] tid,
                               input logic [csf_pkg::COUNT_WIDTH-1:0] need);
        waiter_tid[wq_tail]  = tid;
        waiter_need[wq_tail] = need;
        wq_tail              = wq_tail + 1'b1;
        wq_count++;
    endtask

    // Update the predicted state for one request and queue the responses it causes.
    task automatic semaphore_apply(input csf_pkg::req_t r);
        csf_pkg::rsp_t                  batch[$];
        csf_pkg::rsp_t                  o;
        logic [csf_pkg::FREE_WIDTH-1:0] avail;
        logic [csf_pkg::FREE_WIDTH:0]   sum;
        o = '0;
        if (r.kind == KIND_IGNORED)
            batch.push_back(o);
        else if (r.kind == csf_pkg::KIND_RELEASE_ALL)
        begin
            while (wq_count > 0)
            begin
                o.released_valid  = 1'b1;
                o.released_thread = waiter_tid[wq_head];
                wq_head           = wq_head + 1'b1;
                wq_count--;
                batch.push_back(o);
            end
        end
        else if (r.unit_count == '0)
        begin
            o.status = csf_pkg::STATUS_ZERO;
            batch.push_back(o);
        end
        else if (r.kind == csf_pkg::KIND_WAIT)
        begin
            if (wq_count >= csf_pkg::QUEUE_DEPTH)
                o.status = csf_pkg::STATUS_FULL;
            else if (wq_count > 0)
            begin
                waiter_push(r.thread_id, r.unit_count);
                o.caller_blocked = 1'b1;
            end
            else if (free_units_m >= csf_pkg::FREE_WIDTH'(r.unit_count))
                free_units_m = free_units_m - csf_pkg::FREE_WIDTH'(r.unit_count);
            else
            begin
                // empty queue: block with only the shortfall, all free units go
                waiter_push(r.thread_id,
                            r.unit_count - free_units_m[csf_pkg::COUNT_WIDTH-1:0]);
                free_units_m     = '0;
                o.caller_blocked = 1'b1;
            end
            batch.push_back(o);
        end
        else
        begin
            avail = csf_pkg::FREE_WIDTH'(r.unit_count);
            while (avail != '0 && wq_count > 0)
            begin
                if (avail < csf_pkg::FREE_WIDTH'(waiter_need[wq_head]))
                begin
                    waiter_need[wq_head] = waiter_need[wq_head] -
                                           avail[csf_pkg::COUNT_WIDTH-1:0];
                    avail = '0;
                end
                else
                begin
                    avail             = avail - csf_pkg::FREE_WIDTH'(waiter_need[wq_head]);
                    o.released_valid  = 1'b1;
                    o.released_thread = waiter_tid[wq_head];
                    wq_head           = wq_head + 1'b1;
                    wq_count--;
                    batch.push_back(o);
                end
            end
            sum          = {1'b0, free_units_m} + {1'b0, avail};
            free_units_m = sum[csf_pkg::FREE_WIDTH] ? '1 : sum[csf_pkg::FREE_WIDTH-1:0];
        end
        if (batch.size() == 0)
            batch.push_back(o);
        o      = batch.pop_back();
        o.last = 1'b1;
        batch.push_back(o);
        foreach (batch[i])
            expected_rsp.push_back(batch[i]);
    endtask

    // Response side: check each transfer, then decide the next ready value.
    always @(posedge clk)
    begin : rsp_side
        csf_pkg::rsp_t want;
        int            stall;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            responses_seen++;
            if (expected_rsp.size() == 0)
            begin
                error_count++;
                $display("%0t: response %h with none expected", $time, rsp_data);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp_data.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_data.status);
                end
                if (rsp_data.caller_blocked !== want.caller_blocked)
                begin
                    error_count++;
                    $display("%0t: caller_blocked expected %0d actual %0d",
                             $time, want.caller_blocked, rsp_data.caller_blocked);
                end
                if (rsp_data.released_valid !== want.released_valid)
                begin
                    error_count++;
                    $display("%0t: released_valid expected %0d actual %0d",
                             $time, want.released_valid, rsp_data.released_valid);
                end
                if (rsp_data.released_thread !== want.released_thread)
                begin
                    error_count++;
                    $display("%0t: released_thread expected %0d actual %0d",
                             $time, want.released_thread, rsp_data.released_thread);
                end
                if (rsp_data.last !== want.last)
                begin
                    error_count++;
                    $display("%0t: last expected %0d actual %0d",
                             $time, want.last, rsp_data.last);
                end
            end
        end
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (rsp_stall_left > 0)
        begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            stall = rsp_idle_on ? gap_len() : 0;
            if (stall > 0)
            begin
                rsp_stall_left = stall - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Hold the request until its transfer; valid stays up when the next one follows at once.
    task automatic send_request(input csf_pkg::req_t r);
        int gap;
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        semaphore_apply(r);
        requests_sent++;
        gap = req_idle_on ? gap_len() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_initial_count(input logic [csf_pkg::COUNT_WIDTH-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        free_units_m = csf_pkg::FREE_WIDTH'(value);
    endtask

    task automatic test_directed();
        wait_drained();
        write_initial_count(16'd5);
        send_request(make_req(csf_pkg::KIND_WAIT, 8'h00, 3));          // taken, 2 left
        send_request(make_req(csf_pkg::KIND_WAIT, 8'hFF, 16'hFFFF));   // blocks, shortfall
        send_request(make_req(csf_pkg::KIND_WAIT, 8'h55, 1));          // queued in full
        send_request(make_req(csf_pkg::KIND_WAIT, 8'h33, 0));          // zero count rejected
        send_request(make_req(csf_pkg::KIND_SIGNAL, 8'h33, 0));
        send_request(make_req(KIND_IGNORED, 8'hAA, 16'h5555));
        send_request(make_req(csf_pkg::KIND_SIGNAL, 8'h01, 1));        // partly pays head
        send_request(make_req(csf_pkg::KIND_SIGNAL, 8'h02, 16'hFFFF)); // two released
        send_request(make_req(csf_pkg::KIND_WAIT, 8'h01, 2));          // exactly free count
        send_request(make_req(csf_pkg::KIND_RELEASE_ALL, 8'h00, 0));   // nobody queued
        send_request(make_req(csf_pkg::KIND_WAIT, 8'h10, 4));
        send_request(make_req(csf_pkg::KIND_WAIT, 8'h20, 6));
        send_request(make_req(csf_pkg::KIND_RELEASE_ALL, 8'hFF, 16'hFFFF));
        send_request(make_req(csf_pkg::KIND_SIGNAL, 8'h7F, 7));        // all to free count
        send_request(make_req(csf_pkg::KIND_WAIT, 8'h80, 16'hFFFF));
        send_request(make_req(csf_pkg::KIND_SIGNAL, 8'hC3, 16'hFFFF));
    endtask

    task automatic test_queue_full();
        int i;
        wait_drained();
        write_initial_count(16'd0);
        for (i = 0; i < csf_pkg::QUEUE_DEPTH; i++)
            send_request(make_req(csf_pkg::KIND_WAIT, i * 17, i + 1));
        send_request(make_req(csf_pkg::KIND_WAIT, 8'h99, 1));          // queue full
        send_request(make_req(csf_pkg::KIND_SIGNAL, 8'h99, 6));        // pays first three
        send_request(make_req(csf_pkg::KIND_RELEASE_ALL, 8'h00, 0));   // frees the rest
    endtask

    task automatic test_random(input int items, input logic [csf_pkg::COUNT_WIDTH-1:0] start,
                               input int wait_pct, input int span);
        csf_pkg::req_t r;
        int            i;
        int            roll;
        wait_drained();
        write_initial_count(start);
        for (i = 0; i < items; i++)
        begin
            if (i % 32 == 0)
            begin
                req_idle_on = $urandom_range(0, 3) != 0;
                rsp_idle_on = $urandom_range(0, 3) != 0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 2)
                r.kind = csf_pkg::KIND_RELEASE_ALL;
            else if (roll < 3)
                r.kind = KIND_IGNORED;
            else if (roll < 3 + wait_pct)
                r.kind = csf_pkg::KIND_WAIT;
            else
                r.kind = csf_pkg::KIND_SIGNAL;
            r.thread_id = csf_pkg::THREAD_ID_WIDTH'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (roll < 4)
                r.unit_count = '0;
            else if (roll < 12)
                r.unit_count = csf_pkg::COUNT_WIDTH'($urandom_range(0, 65535));
            else
                r.unit_count = csf_pkg::COUNT_WIDTH'($urandom_range(1, span));
            send_request(r);
        end
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    // Stack full-size signals so the free count runs past 16 bits, then drain it by waits.
    task automatic test_large_counts();
        wait_drained();
        write_initial_count(16'hFFFF);
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        send_request(make_req(csf_pkg::KIND_RELEASE_ALL, 8'h00, 0));
        repeat (BIG_SIGNALS)
            send_request(make_req(csf_pkg::KIND_SIGNAL, $urandom_range(0, 255), 16'hFFFF));
        repeat (BIG_SIGNALS + 2)
            send_request(make_req(csf_pkg::KIND_WAIT, $urandom_range(0, 255), 16'hFFFF));
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_queue_full();
        test_random(70, 16'd0, 65, 6);         // waits dominate: queue fills up
        test_random(70, 16'hFFFF, 50, 40000);
        test_random(70, csf_pkg::COUNT_WIDTH'($urandom_range(1, 20)), 40, 12);
        test_random(60, csf_pkg::COUNT_WIDTH'($urandom_range(0, 65535)), 50, 300);
        test_large_counts();
        wait_drained();
        $display("%0d requests, %0d responses checked: directed cases, full queue,",
                 requests_sent, responses_seen);
        $display("four random phases and a free count grown well past 16 bits.");
        if (error_count == 0 && expected_rsp.size() == 0)
            $display("counting_semaphore_fifo_n_tb: clean");
        else
            $display("counting_semaphore_fifo_n_tb: errors");
        $finish;
    end

endmodule
